[design/vwma_pkg.sv]
`default_nettype none

package vwma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WIN_W = 6;
  localparam logic [WIN_W-1:0] WIN_RESET = 6'd32;

  // A window sum of up to 63 samples of 16 bits fits in 22 signed bits.
  localparam int ACC_W = SAMPLE_W + WIN_W;
  localparam int DIV_CNT_W = $clog2(ACC_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_rd;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

[design/vwma_ctrl.sv]
`default_nettype none

module vwma_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  vwma_pkg::status_t status,
  output vwma_pkg::cmd_t    cmd
);

  vwma_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vwma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      vwma_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = vwma_pkg::ST_READ;
        end
      end
      vwma_pkg::ST_READ: begin
        cmd.rd = 1'b1;
        if (status.last_rd) begin
          state_nxt = vwma_pkg::ST_ACC;
        end
      end
      // The last read word is added to the sum during this cycle.
      vwma_pkg::ST_ACC: begin
        state_nxt = vwma_pkg::ST_DIV_INIT;
      end
      vwma_pkg::ST_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_nxt = vwma_pkg::ST_DIV;
      end
      vwma_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = vwma_pkg::ST_DONE;
        end
      end
      vwma_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = vwma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vwma_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/vwma_dp.sv]
`default_nettype none

module vwma_dp #(
  parameter int STORE_DEPTH = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [vwma_pkg::WIN_W-1:0]          cfg_wr_data,
  input  wire  [vwma_pkg::SAMPLE_W-1:0]       in_tdata,
  input  vwma_pkg::cmd_t                      cmd,
  output vwma_pkg::status_t                   status,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [vwma_pkg::SAMPLE_W-1:0]       out_tdata
);

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SW = vwma_pkg::SAMPLE_W;
  localparam int WW = vwma_pkg::WIN_W;
  localparam int AW = vwma_pkg::ACC_W;
  localparam int CW = vwma_pkg::DIV_CNT_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  logic [SW-1:0]     mem [STORE_DEPTH];

  logic [WW-1:0]     win_len_r;
  logic [WW-1:0]     n_eff;
  logic [WW-1:0]     n_r;
  logic [ADDR_W-1:0] wr_ptr_r;
  logic              wrapped_r;
  logic [ADDR_W-1:0] base_pos_r;
  logic [ADDR_W-1:0] rd_ptr_r;
  logic [WW-1:0]     rd_cnt_r;
  logic [SW-1:0]     rd_data_r;
  logic              rd_vld_r;
  logic              rd_pend_r;
  logic signed [AW-1:0] acc_r;
  logic [AW-1:0]     quo_r;
  logic [WW-1:0]     rem_r;
  logic [WW:0]       rem_sh;
  logic              quo_bit;
  logic              neg_r;
  logic [CW-1:0]     div_cnt_r;
  logic              out_tvalid_r;
  logic [SW-1:0]     out_data_r;
  logic [SW-1:0]     avg_nxt;

  always_comb begin
    if (win_len_r == '0) begin
      n_eff = WW'(1);
    end else if (int'(win_len_r) > STORE_DEPTH) begin
      n_eff = WW'(STORE_DEPTH);
    end else begin
      n_eff = win_len_r;
    end
  end

  // Store entries are written in address order after reset, so before the first
  // wrap only addresses up to the newest write hold real samples.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_ptr_r] <= in_tdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_ptr_r];
      rd_vld_r  <= wrapped_r || (int'(rd_cnt_r) <= int'(base_pos_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r    <= vwma_pkg::WIN_RESET;
      wr_ptr_r     <= '0;
      wrapped_r    <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_len_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        wr_ptr_r <= (wr_ptr_r == LAST_ADDR) ? '0 : wr_ptr_r + 1'b1;
        if (wr_ptr_r == LAST_ADDR) begin
          wrapped_r <= 1'b1;
        end
      end
      rd_pend_r <= cmd.rd;
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign rem_sh  = {rem_r, quo_r[AW-1]};
  assign quo_bit = (rem_sh >= {1'b0, n_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r        <= n_eff;
      base_pos_r <= wr_ptr_r;
      rd_ptr_r   <= wr_ptr_r;
      rd_cnt_r   <= '0;
      acc_r      <= '0;
    end else begin
      if (cmd.rd) begin
        rd_ptr_r <= (rd_ptr_r == '0) ? LAST_ADDR : rd_ptr_r - 1'b1;
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (rd_pend_r && rd_vld_r) begin
        acc_r <= acc_r + {{(AW-SW){rd_data_r[SW-1]}}, rd_data_r};
      end
    end
    if (cmd.div_start) begin
      neg_r     <= acc_r[AW-1];
      quo_r     <= acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[AW-2:0], quo_bit};
      rem_r     <= quo_bit ? WW'(rem_sh - {1'b0, n_r}) : rem_sh[WW-1:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r <= avg_nxt;
    end
  end

  assign avg_nxt = neg_r ? SW'(-quo_r[SW-1:0]) : quo_r[SW-1:0];

  assign status.last_rd  = (rd_cnt_r == n_r - 1'b1);
  assign status.div_done = (div_cnt_r == CW'(AW - 1));
  assign status.out_busy = out_tvalid_r && !out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[design/variable_window_moving_average_top.sv]
`default_nettype none
// An accepted item is handled by one store read per sample of the effective window
// length and a 22-step shift-subtract divide before out_tvalid rises; the next item
// is accepted only after its result is loaded, which waits while a pending result stalls.
// A finished result waits in the output register while the next item is taken in.
// Synchronous active-low reset zeroes the write position, marks the store as unwritten
// (unwritten entries count as zero) and sets the window length to 32.

module variable_window_moving_average_top #(
  parameter int STORE_DEPTH = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire  [vwma_pkg::WIN_W-1:0]         cfg_wr_data,   // window_length
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [vwma_pkg::SAMPLE_W-1:0]      in_tdata,      // [15:0] sample
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [vwma_pkg::SAMPLE_W-1:0]      out_tdata      // [15:0] average
);

  vwma_pkg::cmd_t    cmd;
  vwma_pkg::status_t status;

  vwma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  vwma_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd, cmd.div_start, cmd.div_step, cmd.out_load}))
    else $error("more than one datapath command in a cycle");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_tvalid && !out_tready))
    else $error("result register loaded while a result is still pending");

endmodule

`default_nettype wire
